// File: rtl/fwlw_pkg.sv
// Shared types and constants for the frequency to log weight matrix block.
`timescale 1ns / 1ps
`default_nettype none
package fwlw_pkg;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_LENGTH = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TOTAL_ZERO = 2'd1;
	localparam logic [1:0] ST_ROW_ZERO   = 2'd2;
	localparam logic [1:0] ST_INCOMPLETE = 2'd3;

	localparam int ROW_SUM_W = 22;
	localparam int TOTAL_W   = 26;
	localparam int COUNT_W   = 16;
	localparam int WEIGHT_W  = 40;
	localparam int LOG_W     = 30;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ROW_SUM_W-1:0] ROW_SUM_MAX = '1;
	localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;
	localparam logic [31:0]          LN2_Q32     = 32'hB17217F8;

	typedef struct packed {
		logic [1:0]           status;
		logic                 last;
		logic [3:0]           row;
		logic [5:0]           column;
		logic [COUNT_W-1:0]   count;
		logic [TOTAL_W-1:0]   total;
		logic [ROW_SUM_W-1:0] rowsum;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/fwlw_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/fwlw_queue.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  fwlw_pkg::cmd_t    push_cmd,
	output logic              full,
	input  wire               pop,
	output logic              avail,
	output fwlw_pkg::cmd_t    head
);
	import fwlw_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop && avail) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && avail);
		end
	end
endmodule
`default_nettype wire

// File: rtl/fwlw_front.sv
// Front part: configuration, count storage, row sums and fetch classification.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_front #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_valid,
	output logic           cfg_ready,
	input  wire            cfg_index,
	input  wire [6:0]      cfg_data,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire            action,
	input  wire [15:0]     count,
	output logic           push,
	input  wire            full,
	output fwlw_pkg::cmd_t push_cmd
);
	import fwlw_pkg::*;

	localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
	localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RIDX_W = $clog2(MAX_ROWS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int AW     = $clog2(DEPTH);

	logic                 mode_q;
	logic [6:0]           len_q;
	logic [ROW_SUM_W-1:0] sums_q [MAX_ROWS];
	logic [TOTAL_W-1:0]   total_q;
	logic [RCNT_W-1:0]    load_row_q;
	logic [CIDX_W-1:0]    load_col_q;
	logic [AW-1:0]        load_addr_q;
	logic [RIDX_W-1:0]    fetch_row_q;
	logic [CIDX_W-1:0]    fetch_col_q;
	logic [AW-1:0]        fetch_addr_q;
	logic                 pend_q;
	logic                 pend_ok_q;
	cmd_t                 pend_cmd_q;

	logic [RCNT_W-1:0]    rows;
	logic [10:0]          len_ext;
	logic [CNT_W-1:0]     cols;
	logic                 loaded;
	logic                 any_zero;
	logic                 load_go;
	logic                 fetch_go;
	logic                 cfg_go;
	logic [RIDX_W-1:0]    eff_row;
	logic [CIDX_W-1:0]    eff_col;
	logic [AW-1:0]        eff_addr;
	logic                 load_col_end;
	logic                 fetch_col_end;
	logic                 fetch_row_end;
	logic [TOTAL_W:0]     total_sum;
	logic [COUNT_W-1:0]   ram_rdata;
	cmd_t                 fetch_cmd;

	assign cfg_ready = 1'b1;
	assign in_ready  = !pend_q;
	assign cfg_go    = cfg_valid;
	assign load_go   = in_valid && !pend_q && (action == ACT_LOAD);
	assign fetch_go  = in_valid && !pend_q && (action == ACT_FETCH);

	assign rows    = mode_q ? RCNT_W'(MAX_ROWS) : RCNT_W'(4);
	assign len_ext = {4'b0, len_q};
	always_comb begin
		if (len_ext == 11'd0) begin
			cols = CNT_W'(1);
		end else if (len_ext > 11'(MAX_COLUMNS)) begin
			cols = CNT_W'(MAX_COLUMNS);
		end else begin
			cols = CNT_W'(len_ext);
		end
	end

	assign loaded   = (load_row_q == rows);
	assign eff_row  = loaded ? '0 : load_row_q[RIDX_W-1:0];
	assign eff_col  = loaded ? '0 : load_col_q;
	assign eff_addr = loaded ? '0 : load_addr_q;
	assign load_col_end  = (CNT_W'(eff_col) + CNT_W'(1) == cols);
	assign fetch_col_end = (CNT_W'(fetch_col_q) + CNT_W'(1) == cols);
	assign fetch_row_end = (RCNT_W'(fetch_row_q) + RCNT_W'(1) == rows);
	assign total_sum = {1'b0, loaded ? TOTAL_W'(0) : total_q} + (TOTAL_W+1)'(count);

	always_comb begin
		any_zero = 1'b0;
		for (int i = 0; i < MAX_ROWS; i++) begin
			if (RCNT_W'(i) < rows && sums_q[i] == '0) begin
				any_zero = 1'b1;
			end
		end
	end

	fwlw_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (load_go),
		.waddr(eff_addr),
		.wdata(count),
		.re   (fetch_go),
		.raddr(fetch_addr_q),
		.rdata(ram_rdata)
	);

	assign push = pend_q;
	always_comb begin
		push_cmd       = pend_cmd_q;
		push_cmd.count = pend_ok_q ? ram_rdata : '0;
	end

	always_comb begin
		fetch_cmd      = '0;
		fetch_cmd.last = 1'b1;
		if (!loaded) begin
			fetch_cmd.status = ST_INCOMPLETE;
		end else if (total_q == '0) begin
			fetch_cmd.status = ST_TOTAL_ZERO;
		end else if (any_zero) begin
			fetch_cmd.status = ST_ROW_ZERO;
		end else begin
			fetch_cmd.status = ST_OK;
			fetch_cmd.last   = fetch_col_end && fetch_row_end;
			fetch_cmd.row    = 4'(fetch_row_q);
			fetch_cmd.column = 6'(fetch_col_q);
			fetch_cmd.total  = total_q;
			fetch_cmd.rowsum = sums_q[fetch_row_q];
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_go) begin
			pend_cmd_q <= fetch_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			len_q        <= 7'd1;
			total_q      <= '0;
			load_row_q   <= '0;
			load_col_q   <= '0;
			load_addr_q  <= '0;
			fetch_row_q  <= '0;
			fetch_col_q  <= '0;
			fetch_addr_q <= '0;
			pend_q       <= 1'b0;
			pend_ok_q    <= 1'b0;
			for (int i = 0; i < MAX_ROWS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
			if (cfg_go) begin
				if (cfg_index == CFG_MODE) begin
					mode_q <= cfg_data[0];
				end else begin
					len_q <= cfg_data;
				end
				total_q      <= '0;
				load_row_q   <= '0;
				load_col_q   <= '0;
				load_addr_q  <= '0;
				fetch_row_q  <= '0;
				fetch_col_q  <= '0;
				fetch_addr_q <= '0;
				for (int i = 0; i < MAX_ROWS; i++) begin
					sums_q[i] <= '0;
				end
			end else if (load_go) begin
				for (int i = 0; i < MAX_ROWS; i++) begin
					logic [ROW_SUM_W:0] s;
					s = {1'b0, loaded ? ROW_SUM_W'(0) : sums_q[i]}
						+ ((RIDX_W'(i) == eff_row) ? (ROW_SUM_W+1)'(count) : '0);
					sums_q[i] <= s[ROW_SUM_W] ? ROW_SUM_MAX : s[ROW_SUM_W-1:0];
				end
				total_q <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
				if (load_col_end) begin
					load_col_q <= '0;
					load_row_q <= RCNT_W'(eff_row) + RCNT_W'(1);
				end else begin
					load_col_q <= eff_col + CIDX_W'(1);
					load_row_q <= RCNT_W'(eff_row);
				end
				load_addr_q <= eff_addr + AW'(1);
				if (loaded) begin
					fetch_row_q  <= '0;
					fetch_col_q  <= '0;
					fetch_addr_q <= '0;
				end
			end else if (fetch_go) begin
				pend_q    <= 1'b1;
				pend_ok_q <= loaded && (total_q != '0) && !any_zero;
				if (!loaded || total_q == '0 || any_zero ||
					(fetch_col_end && fetch_row_end)) begin
					fetch_row_q  <= '0;
					fetch_col_q  <= '0;
					fetch_addr_q <= '0;
				end else if (fetch_col_end) begin
					fetch_col_q  <= '0;
					fetch_row_q  <= fetch_row_q + RIDX_W'(1);
					fetch_addr_q <= fetch_addr_q + AW'(1);
				end else begin
					fetch_col_q  <= fetch_col_q + CIDX_W'(1);
					fetch_addr_q <= fetch_addr_q + AW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/fwlw_log.sv
// Iterative log2 unit: normalization shifts, then one mantissa squaring per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_log (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [fwlw_pkg::TOTAL_W-1:0]   x,
	output logic                          done,
	output logic [fwlw_pkg::LOG_W-1:0]    result
);
	import fwlw_pkg::*;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_SQ   = 2'd2;
	localparam logic [1:0] L_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [30:0] m_q;
	logic [4:0]  e_q;
	logic [4:0]  bit_q;
	logic [61:0] sq;

	assign done = (state_q == L_DONE);
	assign sq   = 62'(m_q) * 62'(m_q);

	always_ff @(posedge clk) begin
		if (start && (state_q == L_IDLE || state_q == L_DONE)) begin
			m_q    <= 31'(x);
			e_q    <= 5'd30;
			bit_q  <= 5'd23;
			result <= '0;
		end else if (state_q == L_NORM) begin
			if (m_q[30]) begin
				result[29:24] <= {1'b0, e_q};
			end else if (m_q[30:27] == 4'd0) begin
				m_q <= m_q << 4;
				e_q <= e_q - 5'd4;
			end else begin
				m_q <= m_q << 1;
				e_q <= e_q - 5'd1;
			end
		end else if (state_q == L_SQ) begin
			if (sq[61]) begin
				result[bit_q] <= 1'b1;
				m_q <= sq[61:31];
			end else begin
				m_q <= sq[60:30];
			end
			bit_q <= bit_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE, L_DONE: begin
					state_q <= start ? L_NORM : L_IDLE;
				end
				L_NORM: begin
					if (m_q == '0) begin
						state_q <= L_DONE;
					end else if (m_q[30]) begin
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					if (bit_q == 5'd0) begin
						state_q <= L_DONE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/fwlw_back.sv
// Back part: log difference, scaling by ln2 and count, and the output register.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 avail,
	input  fwlw_pkg::cmd_t      head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [39:0]         weight,
	output logic [1:0]          status,
	output logic [3:0]          row,
	output logic [5:0]          column,
	output logic                last
);
	import fwlw_pkg::*;

	localparam logic [2:0] B_IDLE   = 3'd0;
	localparam logic [2:0] B_LOGT   = 3'd1;
	localparam logic [2:0] B_STARTR = 3'd2;
	localparam logic [2:0] B_LOGR   = 3'd3;
	localparam logic [2:0] B_MULW   = 3'd4;
	localparam logic [2:0] B_EMIT   = 3'd5;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic [LOG_W-1:0]   lt_q;
	logic [LOG_W-1:0]   ln_s1;
	logic [WEIGHT_W-1:0] w_q;
	logic               log_start;
	logic [TOTAL_W-1:0] log_x;
	logic               log_done;
	logic [LOG_W-1:0]   log_res;
	logic [LOG_W-1:0]   diff;
	logic [61:0]        ln_prod;
	logic [46:0]        w_prod;

	assign pop       = (state_q == B_IDLE) && avail;
	assign log_start = (pop && head.status == ST_OK) || (state_q == B_STARTR);
	assign log_x     = (state_q == B_STARTR) ? TOTAL_W'(cmd_q.rowsum) : head.total;
	assign diff      = (lt_q > log_res) ? lt_q - log_res : '0;
	assign ln_prod   = 62'(diff) * 62'(LN2_Q32);
	assign w_prod    = 47'(cmd_q.count) * 47'(ln_s1) + 47'd128;

	fwlw_log u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.x     (log_x),
		.done  (log_done),
		.result(log_res)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
			w_q   <= '0;
		end
		if (state_q == B_LOGT && log_done) begin
			lt_q <= log_res;
		end
		if (state_q == B_LOGR && log_done) begin
			ln_s1 <= ln_prod[61:32];
		end
		if (state_q == B_MULW) begin
			w_q <= WEIGHT_W'(w_prod[46:8]);
		end
		if (state_q == B_EMIT && (!out_valid || out_ready)) begin
			weight <= w_q;
			status <= cmd_q.status;
			row    <= cmd_q.row;
			column <= cmd_q.column;
			last   <= cmd_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == B_EMIT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (avail) begin
						state_q <= (head.status == ST_OK) ? B_LOGT : B_EMIT;
					end
				end
				B_LOGT: begin
					if (log_done) begin
						state_q <= B_STARTR;
					end
				end
				B_STARTR: state_q <= B_LOGR;
				B_LOGR: begin
					if (log_done) begin
						state_q <= B_MULW;
					end
				end
				B_MULW: state_q <= B_EMIT;
				B_EMIT: begin
					if (!out_valid || out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/frequency_to_log_weight_matrix.sv
// Top level of the frequency to log weight matrix block.
// A load item does not hold the input; the next item may follow in the next cycle.
// A fetch item reads the count memory and waits in the front until the queue has room;
// the back then runs two log2 evaluations on one shared unit (normalization shifts, then
// a squaring loop) and the ln2 and count multiplies before it takes the next command.
// Reset restores the default configuration and clears sums, positions and queues; the count memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module frequency_to_log_weight_matrix #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire [6:0]   cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         action,
	input  wire [15:0]  count,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [39:0] weight,
	output logic [1:0]  status,
	output logic [3:0]  row,
	output logic [5:0]  column,
	output logic        last
);
	import fwlw_pkg::*;

	logic push;
	logic full;
	cmd_t push_cmd;
	logic pop;
	logic avail;
	cmd_t head;

	fwlw_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.count    (count),
		.push     (push),
		.full     (full),
		.push_cmd (push_cmd)
	);

	fwlw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.avail   (avail),
		.head    (head)
	);

	fwlw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.weight   (weight),
		.status   (status),
		.row      (row),
		.column   (column),
		.last     (last)
	);
endmodule
`default_nettype wire

// File: rtl/fwlw_checker.sv
// Port-level assertions for the frequency to log weight matrix block.
`timescale 1ns / 1ps
`default_nettype none
module fwlw_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        cfg_valid,
	input wire        cfg_ready,
	input wire        cfg_index,
	input wire [6:0]  cfg_data,
	input wire        in_valid,
	input wire        in_ready,
	input wire        action,
	input wire [15:0] count,
	input wire        out_valid,
	input wire        out_ready,
	input wire [39:0] weight,
	input wire [1:0]  status,
	input wire [3:0]  row,
	input wire [5:0]  column,
	input wire        last
);
	import fwlw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output item dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(weight) && $stable(status) && $stable(last))
		else $error("Output item changed while stalled.");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && weight == '0)
		else $error("Error item without last or with a nonzero weight.");

	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> row == '0 && column == '0)
		else $error("Error item with a nonzero position.");
endmodule

bind frequency_to_log_weight_matrix fwlw_checker u_fwlw_checker (.*);
`default_nettype wire
